// ===== sv/sbl_pkg.sv =====
// shared types and constants of the stack blur line filter
// no dependencies
`default_nettype none
package sbl_pkg;
	localparam int MAX_RADIUS = 32;
	localparam int DEPTH      = 2 * MAX_RADIUS + 1;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = 7;
	localparam int RAD_W      = 6;
	localparam int ACC_W      = 19;
	localparam int DIV_W      = 11;
	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;
	localparam logic [2:0] ADDR_RADIUS = 3'd0;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
		pixel_t           data;
	} win_wr_t;

	// one job: a single mid-line result or a line-end drain
	typedef struct packed {
		logic [PTR_W-1:0] ptr;
		logic [CNT_W-1:0] n;
		logic [RAD_W-1:0] r;
		logic [RAD_W-1:0] center;
		logic             multi;
	} job_t;
endpackage
`default_nettype wire

// ===== sv/sbl_front.sv =====
// front end: takes pixels, writes the window, turns beats into jobs
// depends on sbl_pkg
`default_nettype none
module sbl_front import sbl_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             idle,
	input  wire pixel_t           pix,
	input  wire logic             line_end,
	input  wire logic [RAD_W-1:0] radius,
	output logic                  in_ready,
	output win_wr_t               wr,
	output logic                  push,
	output job_t                  job
);
	logic [PTR_W-1:0] wptr_q;
	logic [CNT_W-1:0] seen_q;
	logic [PTR_W-1:0] nptr;
	logic [CNT_W-1:0] n;
	logic [RAD_W-1:0] r;
	logic [CNT_W-1:0] nm1;
	logic             acc_beat;

	assign in_ready = idle;
	assign acc_beat = in_valid && in_ready;
	assign nptr = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
	assign n    = (seen_q < CNT_MAX) ? seen_q + 1'b1 : CNT_MAX;
	assign nm1  = n - 1'b1;
	assign r    = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;

	always_comb begin
		wr.en   = acc_beat;
		wr.addr = nptr;
		wr.data = pix;
		job.ptr = nptr;
		job.n   = n;
		job.r   = r;
		job.multi = line_end;
		if (line_end) begin
			job.center = ({1'b0, r} < nm1) ? r : RAD_W'(nm1);
			push = acc_beat;
		end else begin
			job.center = r;
			push = acc_beat && (nm1 >= {1'b0, r});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			seen_q <= '0;
		end else if (acc_beat) begin
			wptr_q <= nptr;
			seen_q <= line_end ? '0 : n;
		end
	end
endmodule
`default_nettype wire

// ===== sv/sbl_job_fifo.sv =====
// two-entry job queue between front and back
// depends on sbl_pkg
`default_nettype none
module sbl_job_fifo import sbl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wdata,
	input  wire logic pop,
	output job_t      rdata,
	output logic      empty
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2)) else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("job queue underflow");
	a_single_job: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (cnt_q != 2'd0)) else $error("pushed job lost");
endmodule
`default_nettype wire

// ===== sv/sbl_back.sv =====
// back end: window memory, tap accumulate, divide, output register
// depends on sbl_pkg
`default_nettype none
module sbl_back import sbl_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire win_wr_t wr,
	input  wire logic    job_avail,
	input  wire job_t    job,
	output logic         pop,
	output logic         idle,
	output logic         out_valid,
	input  wire logic    out_ready,
	output pixel_t       out_pix,
	output logic         line_end_out,
	output logic         run_end
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MAC  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	pixel_t win_q [DEPTH];
	pixel_t rd_s1;
	logic [RAD_W-1:0] w_s1;
	logic             v_s1;

	state_t           state_q;
	job_t             job_q;
	logic [RAD_W-1:0] center_q;
	logic [PTR_W-1:0] k_q;
	logic [DIV_W-1:0] div_q;
	logic [ACC_W-1:0] acc_q [4];
	logic [7:0]       quo_q [4];
	logic [2:0]       bit_q;
	logic             out_valid_q;
	pixel_t           out_q;
	logic             lend_q, rend_q;

	logic             issue;
	logic signed [7:0] d, j;
	logic [PTR_W-1:0] jmax, jc, absd;
	logic [RAD_W-1:0] wgt;
	logic [7:0]       addr_w;
	logic [PTR_W-1:0] raddr;
	logic [ACC_W-1:0] trial;
	logic             last;
	logic [RAD_W:0]   rp1;
	logic             out_load;

	assign pop  = (state_q == ST_IDLE) && job_avail;
	assign idle = (state_q == ST_IDLE) && !job_avail;
	assign last = !job_q.multi || (center_q == '0);
	assign rp1  = {1'b0, job.r} + 1'b1;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// tap address generation
	always_comb begin
		issue = (state_q == ST_MAC) && (k_q <= {job_q.r, 1'b0});
		d = $signed({1'b0, k_q}) - $signed({2'b00, job_q.r});
		j = $signed({2'b00, center_q}) - d;
		jmax = ((job_q.n - 1'b1) > CNT_W'(DEPTH - 1)) ? PTR_W'(DEPTH - 1)
			: PTR_W'(job_q.n - 1'b1);
		if (j < 0) jc = '0;
		else if (PTR_W'(j) > jmax) jc = jmax;
		else jc = PTR_W'(j);
		absd = d[7] ? PTR_W'(-d) : PTR_W'(d);
		wgt = RAD_W'({1'b0, job_q.r} + 1'b1 - absd);
		if (job_q.ptr >= jc) addr_w = {1'b0, job_q.ptr} - {1'b0, jc};
		else addr_w = {1'b0, job_q.ptr} + 8'(DEPTH) - {1'b0, jc};
		raddr = addr_w[PTR_W-1:0];
		// divisor aligned to quotient bit bit_q
		trial = ACC_W'({div_q, 7'd0} >> (3'd7 - bit_q));
	end

	always_ff @(posedge clk) begin
		if (wr.en) win_q[wr.addr] <= wr.data;
		rd_s1 <= win_q[raddr];
		w_s1  <= wgt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			bit_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) out_valid_q <= 1'b0;
			v_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (job_avail) begin
						job_q    <= job;
						center_q <= job.center;
						div_q    <= DIV_W'(rp1) * DIV_W'(rp1);
						k_q      <= '0;
						for (int c = 0; c < 4; c++) acc_q[c] <= '0;
						state_q  <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (issue) k_q <= k_q + 1'b1;
					if (v_s1) begin
						acc_q[0] <= acc_q[0] + ACC_W'(w_s1) * ACC_W'(rd_s1.red);
						acc_q[1] <= acc_q[1] + ACC_W'(w_s1) * ACC_W'(rd_s1.green);
						acc_q[2] <= acc_q[2] + ACC_W'(w_s1) * ACC_W'(rd_s1.blue);
						acc_q[3] <= acc_q[3] + ACC_W'(w_s1) * ACC_W'(rd_s1.alpha);
					end else if (!issue) begin
						bit_q   <= 3'd7;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					for (int c = 0; c < 4; c++) begin
						if (acc_q[c] >= trial) begin
							acc_q[c] <= acc_q[c] - trial;
							quo_q[c][bit_q] <= 1'b1;
						end else begin
							quo_q[c][bit_q] <= 1'b0;
						end
					end
					if (bit_q == '0) state_q <= ST_OUT;
					else bit_q <= bit_q - 1'b1;
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_q  <= '{alpha: quo_q[3], blue: quo_q[2],
							green: quo_q[1], red: quo_q[0]};
						lend_q <= job_q.multi && last;
						rend_q <= last;
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							center_q <= center_q - 1'b1;
							k_q      <= '0;
							for (int c = 0; c < 4; c++) acc_q[c] <= '0;
							state_q  <= ST_MAC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pix      = out_q;
	assign line_end_out = lend_q;
	assign run_end      = rend_q;

	a_tap_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> ({1'b0, jc} < {1'b0, job_q.n})) else $error("tap outside line");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_MAC)) else $error("job popped while busy");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_IDLE)) else $error("window written while busy");
endmodule
`default_nettype wire

// ===== sv/stack_blur_line_filter_unit.sv =====
// top level of the stack blur line filter: register port, front, queue, back
// depends on sbl_pkg, sbl_front, sbl_job_fifo, sbl_back
//
// channel   | signals                                   | direction
// ----------+-------------------------------------------+----------
// pixel in  | in_valid/in_ready, in_red..in_alpha, line_end_in | in
// pixel out | out_valid/out_ready, out_red..out_alpha, line_end_out, run_end | out
// config    | psel penable pwrite paddr pwdata prdata pready | apb
//
// each result takes a tap accumulate pass over the window, 8 divide steps and
// one output load, which can stall on out_ready; the pace is set by the single
// window read port and the bit-serial divider; a job is popped in the idle state
// a beat that causes no result does not stall the input; a line end drains
// min(r, n-1)+1 results one after another; the input waits while a job runs
// reset clears control state, radius, and the line count; the window is
// only ever read at pixels of the current line so it needs no clearing
`default_nettype none
module stack_blur_line_filter_unit import sbl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_red,
	input  wire logic [7:0]  in_green,
	input  wire logic [7:0]  in_blue,
	input  wire logic [7:0]  in_alpha,
	input  wire logic        line_end_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  out_red,
	output logic      [7:0]  out_green,
	output logic      [7:0]  out_blue,
	output logic      [7:0]  out_alpha,
	output logic             line_end_out,
	output logic             run_end
);
	logic [RAD_W-1:0] radius_q;
	logic             idle_back, fifo_empty, push, pop;
	job_t             job_in, job_out;
	win_wr_t          wr;
	pixel_t           pix_in, pix_out;

	// register port, radius is the only register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == ADDR_RADIUS[2])) begin
			radius_q <= pwdata[RAD_W-1:0];
		end
	end
	assign prdata = (paddr[2] == ADDR_RADIUS[2]) ? {26'd0, radius_q} : 32'd0;

	assign pix_in = '{alpha: in_alpha, blue: in_blue, green: in_green, red: in_red};

	sbl_front u_front (
		.clk, .arst_n, .in_valid,
		.idle     (idle_back && fifo_empty),
		.pix      (pix_in),
		.line_end (line_end_in),
		.radius   (radius_q),
		.in_ready,
		.wr, .push,
		.job      (job_in)
	);

	sbl_job_fifo u_fifo (
		.clk, .arst_n, .push,
		.wdata (job_in),
		.pop,
		.rdata (job_out),
		.empty (fifo_empty)
	);

	sbl_back u_back (
		.clk, .arst_n, .wr,
		.job_avail (!fifo_empty),
		.job       (job_out),
		.pop,
		.idle      (idle_back),
		.out_valid, .out_ready,
		.out_pix   (pix_out),
		.line_end_out, .run_end
	);

	assign out_red   = pix_out.red;
	assign out_green = pix_out.green;
	assign out_blue  = pix_out.blue;
	assign out_alpha = pix_out.alpha;
endmodule
`default_nettype wire
